[hdl/bounded_ordered_list_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bounded ordered list
// Shared property wrappers, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_TOP_MACROS_SVH
`define BOUNDED_ORDERED_LIST_TOP_MACROS_SVH

// Same-cycle implication
`define BOL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BOL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bol_pkg.sv]
// ----------------------------------------------------------------------------
// bol_pkg
// Operation and status codes, register map and cell command for the list.
// ----------------------------------------------------------------------------
package bol_pkg;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_APPEND = 2'd1,
        FN_READ   = 2'd2,
        FN_DELETE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    localparam int          ADDR_W         = 2;
    localparam int          CAP_W          = 5;
    localparam int          POS_W          = 5;
    localparam int          FILL_W         = 5;
    localparam int          WORD_W         = 32;
    localparam logic [ADDR_W-1:0] ADDR_CAPACITY  = 2'd0;
    localparam logic [CAP_W-1:0]  CAPACITY_RESET = 5'd16;

    // Broadcast to every cell: move up from the position, or move down onto it
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_cmd;

endpackage

[hdl/bol_cell.sv]
// ----------------------------------------------------------------------------
// bol_cell
// One slot of the list; takes the new entry, or its lower or upper neighbour on a shift.
// ----------------------------------------------------------------------------
module bol_cell #(
    parameter int INDEX = 0,
    parameter int PW    = 5,
    parameter int EW    = 32
) (
    input  logic               i_clk,
    input  bol_pkg::t_cell_cmd i_cmd,
    input  logic [PW-1:0]      i_position,
    input  logic [EW-1:0]      i_entry,
    input  logic [EW-1:0]      i_lower,
    input  logic [EW-1:0]      i_upper,
    output logic [EW-1:0]      o_entry
);

    localparam logic [PW-1:0] MY_INDEX = PW'(INDEX);

    logic [EW-1:0] r_data;
    logic [EW-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (MY_INDEX > i_position) begin
                n_data = i_lower;
            end else if (MY_INDEX == i_position) begin
                n_data = i_entry;
            end
        end else if (i_cmd.del) begin
            if (MY_INDEX >= i_position) begin
                n_data = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_entry = r_data;

endmodule

[hdl/bol_ctrl.sv]
// ----------------------------------------------------------------------------
// bol_ctrl
// Request decode, full and position checks, fill count.
// ----------------------------------------------------------------------------
module bol_ctrl #(
    parameter int DEPTH = 16,
    parameter int PW    = 5,
    parameter int CW    = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [1:0]                  i_func,
    input  logic [bol_pkg::POS_W-1:0]   i_position,
    input  logic [bol_pkg::CAP_W-1:0]   i_capacity,
    output bol_pkg::t_cell_cmd          o_cmd,
    output logic [PW-1:0]               o_position,
    output bol_pkg::t_status            o_status,
    output logic                        o_read_ok,
    output logic [PW-1:0]               o_count_next
);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_cnt;
    logic [PW-1:0] w_cap;
    logic [PW-1:0] w_limit;

    assign w_pos   = PW'(i_position);
    assign w_cnt   = PW'(r_count);
    assign w_cap   = PW'(i_capacity);
    assign w_limit = (w_cap < PW'(DEPTH)) ? w_cap : PW'(DEPTH);

    always_comb begin
        o_cmd      = '0;
        o_position = w_pos;
        o_status   = bol_pkg::ST_OK;
        o_read_ok  = 1'b0;
        n_count    = r_count;
        unique case (bol_pkg::t_func'(i_func)) inside
            bol_pkg::FN_INSERT,
            bol_pkg::FN_APPEND: begin
                if (bol_pkg::t_func'(i_func) == bol_pkg::FN_APPEND) begin
                    o_position = w_cnt;
                end
                if (w_cnt >= w_limit) begin
                    o_status = bol_pkg::ST_FULL;
                end else if (o_position > w_cnt) begin
                    o_status = bol_pkg::ST_BADPOS;
                end else begin
                    o_cmd.ins = i_start;
                    if (i_start) begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            bol_pkg::FN_READ: begin
                if (w_pos < w_cnt) begin
                    o_read_ok = 1'b1;
                end else begin
                    o_status = bol_pkg::ST_BADPOS;
                end
            end
            bol_pkg::FN_DELETE: begin
                if (w_pos < w_cnt) begin
                    o_cmd.del = i_start;
                    if (i_start) begin
                        n_count = r_count - CW'(1);
                    end
                end else begin
                    o_status = bol_pkg::ST_BADPOS;
                end
            end
            default: begin
                o_status = bol_pkg::ST_BADPOS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count_next = PW'(n_count);

endmodule

[hdl/bounded_ordered_list_top.sv]
// A request taken at one edge has its result word on the ports in the
// next cycle, strobed by o_valid for exactly that cycle.
// Throughput: one request per cycle; busy stays low, as every cell shifts in parallel.
// Reset (synchronous, i_rst_n low): fill count to zero, capacity to 16, no result.
// Entry cells are not cleared; only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
// bounded_ordered_list_top
// Bounded ordered list built as a row of entry cells with insert, append,
// read and delete at a position, limited by a programmable capacity.
// ----------------------------------------------------------------------------
`include "bounded_ordered_list_top_macros.svh"

module bounded_ordered_list_top #(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request side
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_func,
    input  logic [bol_pkg::POS_W-1:0]         i_position,
    input  logic [bol_pkg::WORD_W-1:0]        i_entry_value,
    // result side
    output logic                              o_valid,
    output logic [1:0]                        o_status,
    output logic [bol_pkg::WORD_W-1:0]        o_read_value,
    output logic [bol_pkg::FILL_W-1:0]        o_fill_level,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bol_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // count must hold DEPTH itself; position compares need at least 5 bits
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > bol_pkg::POS_W) ? CW : bol_pkg::POS_W;
    localparam int AW = $clog2(DEPTH);

    // ---------------- configuration register ----------------
    logic [bol_pkg::CAP_W-1:0] r_capacity;
    logic                      w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == bol_pkg::ADDR_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bol_pkg::CAPACITY_RESET;
        end else if (w_cfg_wr) begin
            r_capacity <= pwdata[bol_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr == bol_pkg::ADDR_CAPACITY) ? 32'(r_capacity) : 32'd0;

    // ---------------- control ----------------
    // never busy: the cells and fill count update at the edge that takes a request
    assign busy = 1'b0;

    bol_pkg::t_cell_cmd w_cmd;
    bol_pkg::t_status   w_status;
    logic [PW-1:0]      w_pos;
    logic [PW-1:0]      w_count_next;
    logic               w_read_ok;
    logic               w_accept;

    assign w_accept = start && !busy;

    bol_ctrl #(
        .DEPTH (DEPTH),
        .PW    (PW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_accept),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_capacity   (r_capacity),
        .o_cmd        (w_cmd),
        .o_position   (w_pos),
        .o_status     (w_status),
        .o_read_ok    (w_read_ok),
        .o_count_next (w_count_next)
    );

    // ---------------- row of entry cells ----------------
    // Input word is kept in its low ENTRY_WIDTH bits, zero above 32.
    logic [63:0]            w_val64;
    logic [ENTRY_WIDTH-1:0] w_val;
    logic [ENTRY_WIDTH-1:0] w_entry [DEPTH];

    assign w_val64 = 64'(i_entry_value);
    assign w_val   = w_val64[ENTRY_WIDTH-1:0];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        // end cells see themselves where a neighbour is missing
        localparam int LO = (g == 0) ? 0 : g - 1;
        localparam int HI = (g == DEPTH - 1) ? g : g + 1;

        bol_cell #(
            .INDEX (g),
            .PW    (PW),
            .EW    (ENTRY_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_position (w_pos),
            .i_entry    (w_val),
            .i_lower    (w_entry[LO]),
            .i_upper    (w_entry[HI]),
            .o_entry    (w_entry[g])
        );
    end

    // ---------------- read select and result word ----------------
    // position is below the fill count whenever the read is good, so the
    // index is always a real slot
    logic [63:0]                 w_rd64;
    logic                        r_valid;
    logic [1:0]                  r_status;
    logic [bol_pkg::WORD_W-1:0]  r_rdata;
    logic [bol_pkg::FILL_W-1:0]  r_fill;
    logic [bol_pkg::WORD_W-1:0]  n_rdata;

    assign w_rd64  = 64'(w_entry[w_pos[AW-1:0]]);
    assign n_rdata = w_read_ok ? w_rd64[bol_pkg::WORD_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_rdata  <= n_rdata;
            r_fill   <= w_count_next[bol_pkg::FILL_W-1:0];
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_read_value = r_rdata;
    assign o_fill_level = r_fill;

    // ---------------- checks ----------------
    `BOL_ASSERT_NXT(a_one_cycle, w_accept, o_valid, "request gave no result next cycle")
    `BOL_ASSERT_IMP(a_no_spurious, o_valid, $past(w_accept), "result without a request")
    `BOL_ASSERT_IMP(a_err_zero, o_valid && (o_status != bol_pkg::ST_OK), o_read_value == '0, "failed request returned data")
    `BOL_ASSERT_IMP(a_err_keeps_fill, w_accept && (w_status != bol_pkg::ST_OK), w_count_next == PW'(u_ctrl.r_count), "failed request moved the fill count")

endmodule
